/* sv/skinned_vertex_bounds_assert.svh */
`ifndef SKINNED_VERTEX_BOUNDS_ASSERT_SVH
`define SKINNED_VERTEX_BOUNDS_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define SVB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define SVB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/svb_pkg.sv */
package svb_pkg;

  localparam logic [4:0]         STEP_LAST = 5'd26;
  localparam logic signed [63:0] ROUND     = 64'sd536870912;
  localparam logic signed [31:0] HALF_Q16  = 32'sd32768;
  localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN   = 32'sh80000000;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        joint_index;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic [30:0]       bias;
    logic              last_weight;
    logic              frame_start;
  } in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } out_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] rot_w;
  } joint_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic ok;
  } eng_ctl_t;

  typedef enum logic [3:0] {
    OP_QX, OP_QY, OP_QZ, OP_QW,
    OP_VX, OP_VY, OP_VZ,
    OP_TW, OP_TX, OP_TY, OP_TZ,
    OP_U0, OP_U1, OP_U2,
    OP_BIAS
  } opnd_e;

  typedef enum logic [1:0] {
    DST_T,
    DST_U,
    DST_S
  } dest_e;

  typedef struct packed {
    opnd_e      a;
    opnd_e      b;
    logic       neg;
    logic       first;
    logic       last;
    dest_e      dest;
    logic [1:0] di;
  } step_t;

  function automatic step_t mk(opnd_e a, opnd_e b, logic neg, logic first, logic last,
                               dest_e dest, logic [1:0] di);
    step_t s;
    s.a = a; s.b = b; s.neg = neg; s.first = first; s.last = last;
    s.dest = dest; s.di = di;
    return s;
  endfunction

  function automatic step_t step_info(logic [4:0] step);
    step_t s;
    s = mk(OP_QX, OP_VX, 1'b0, 1'b0, 1'b0, DST_T, 2'd0);
    unique case (step)
      5'd0:  s = mk(OP_QX, OP_VX,   1'b1, 1'b1, 1'b0, DST_T, 2'd0);
      5'd1:  s = mk(OP_QY, OP_VY,   1'b1, 1'b0, 1'b0, DST_T, 2'd0);
      5'd2:  s = mk(OP_QZ, OP_VZ,   1'b1, 1'b0, 1'b1, DST_T, 2'd0);
      5'd3:  s = mk(OP_QW, OP_VX,   1'b0, 1'b1, 1'b0, DST_T, 2'd1);
      5'd4:  s = mk(OP_QY, OP_VZ,   1'b0, 1'b0, 1'b0, DST_T, 2'd1);
      5'd5:  s = mk(OP_QZ, OP_VY,   1'b1, 1'b0, 1'b1, DST_T, 2'd1);
      5'd6:  s = mk(OP_QW, OP_VY,   1'b0, 1'b1, 1'b0, DST_T, 2'd2);
      5'd7:  s = mk(OP_QX, OP_VZ,   1'b1, 1'b0, 1'b0, DST_T, 2'd2);
      5'd8:  s = mk(OP_QZ, OP_VX,   1'b0, 1'b0, 1'b1, DST_T, 2'd2);
      5'd9:  s = mk(OP_QW, OP_VZ,   1'b0, 1'b1, 1'b0, DST_T, 2'd3);
      5'd10: s = mk(OP_QX, OP_VY,   1'b0, 1'b0, 1'b0, DST_T, 2'd3);
      5'd11: s = mk(OP_QY, OP_VX,   1'b1, 1'b0, 1'b1, DST_T, 2'd3);
      5'd12: s = mk(OP_TW, OP_QX,   1'b1, 1'b1, 1'b0, DST_U, 2'd0);
      5'd13: s = mk(OP_TX, OP_QW,   1'b0, 1'b0, 1'b0, DST_U, 2'd0);
      5'd14: s = mk(OP_TY, OP_QZ,   1'b1, 1'b0, 1'b0, DST_U, 2'd0);
      5'd15: s = mk(OP_TZ, OP_QY,   1'b0, 1'b0, 1'b1, DST_U, 2'd0);
      5'd16: s = mk(OP_TW, OP_QY,   1'b1, 1'b1, 1'b0, DST_U, 2'd1);
      5'd17: s = mk(OP_TX, OP_QZ,   1'b0, 1'b0, 1'b0, DST_U, 2'd1);
      5'd18: s = mk(OP_TY, OP_QW,   1'b0, 1'b0, 1'b0, DST_U, 2'd1);
      5'd19: s = mk(OP_TZ, OP_QX,   1'b1, 1'b0, 1'b1, DST_U, 2'd1);
      5'd20: s = mk(OP_TW, OP_QZ,   1'b1, 1'b1, 1'b0, DST_U, 2'd2);
      5'd21: s = mk(OP_TX, OP_QY,   1'b1, 1'b0, 1'b0, DST_U, 2'd2);
      5'd22: s = mk(OP_TY, OP_QX,   1'b0, 1'b0, 1'b0, DST_U, 2'd2);
      5'd23: s = mk(OP_TZ, OP_QW,   1'b0, 1'b0, 1'b1, DST_U, 2'd2);
      5'd24: s = mk(OP_U0, OP_BIAS, 1'b0, 1'b1, 1'b1, DST_S, 2'd0);
      5'd25: s = mk(OP_U1, OP_BIAS, 1'b0, 1'b1, 1'b1, DST_S, 2'd1);
      5'd26: s = mk(OP_U2, OP_BIAS, 1'b0, 1'b1, 1'b1, DST_S, 2'd2);
      default: s = mk(OP_QX, OP_VX, 1'b0, 1'b0, 1'b0, DST_T, 2'd0);
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [49:0] v);
    if (v > 50'(S32_MAX)) return S32_MAX;
    if (v < 50'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [49:0] v);
    if (v > 50'sh7fffffffffff) return 48'sh7fffffffffff;
    if (v < -50'sh800000000000) return 48'sh800000000000;
    return v[47:0];
  endfunction

endpackage

/* sv/svb_joint_mem.sv */
module svb_joint_mem
  import svb_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  joint_t        wdata,
  output joint_t        rdata
);

  joint_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/svb_engine.sv */
module svb_engine
  import svb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  eng_ctl_t           ctl,
  input  joint_t             joint,
  input  logic signed [31:0] vec [3],
  input  logic [30:0]        bias,
  output logic signed [47:0] sum [3],
  output logic               done
);

  logic signed [31:0] q [4];
  logic signed [31:0] p [3];
  logic signed [31:0] v [3];
  logic signed [31:0] t [4];
  logic signed [31:0] u [3];
  logic signed [31:0] bias_s;
  logic [4:0]         step;
  logic               run;
  step_t              info;
  step_t              info_d;
  logic               vld_d;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [33:0] term;
  logic signed [34:0] sterm;
  logic signed [37:0] acc;
  logic signed [37:0] acc_next;

  function automatic logic signed [31:0] pick(opnd_e c, logic signed [31:0] qq [4],
                                              logic signed [31:0] vv [3],
                                              logic signed [31:0] tt [4],
                                              logic signed [31:0] uu [3],
                                              logic signed [31:0] bb);
    logic signed [31:0] r;
    case (c)
      OP_QX:   r = qq[0];
      OP_QY:   r = qq[1];
      OP_QZ:   r = qq[2];
      OP_QW:   r = qq[3];
      OP_VX:   r = vv[0];
      OP_VY:   r = vv[1];
      OP_VZ:   r = vv[2];
      OP_TW:   r = tt[0];
      OP_TX:   r = tt[1];
      OP_TY:   r = tt[2];
      OP_TZ:   r = tt[3];
      OP_U0:   r = uu[0];
      OP_U1:   r = uu[1];
      OP_U2:   r = uu[2];
      default: r = bb;
    endcase
    return r;
  endfunction

  assign info     = step_info(step);
  assign opa      = pick(info.a, q, v, t, u, bias_s);
  assign opb      = pick(info.b, q, v, t, u, bias_s);
  assign rnd      = prod + ROUND;
  assign term     = rnd[63:30];
  assign sterm    = info_d.neg ? -35'(term) : 35'(term);
  assign acc_next = (info_d.first ? 38'sd0 : acc) + 38'(sterm);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q[0]   <= ctl.ok ? joint.rot_x : '0;
      q[1]   <= ctl.ok ? joint.rot_y : '0;
      q[2]   <= ctl.ok ? joint.rot_z : '0;
      q[3]   <= ctl.ok ? joint.rot_w : '0;
      p[0]   <= ctl.ok ? joint.pos_x : '0;
      p[1]   <= ctl.ok ? joint.pos_y : '0;
      p[2]   <= ctl.ok ? joint.pos_z : '0;
      v      <= vec;
      bias_s <= signed'({1'b0, bias});
    end
    prod   <= 64'(opa) * 64'(opb);
    info_d <= info;
    if (vld_d) begin
      acc <= acc_next;
      if (info_d.last && info_d.dest == DST_T) begin
        t[info_d.di] <= sat32(50'(acc_next));
      end
      if (info_d.last && info_d.dest == DST_U) begin
        u[info_d.di] <= sat32(50'(acc_next) + 50'(p[info_d.di]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      step  <= '0;
      vld_d <= 1'b0;
      done  <= 1'b0;
      sum   <= '{default: '0};
    end else begin
      vld_d <= run;
      done  <= vld_d && info_d.dest == DST_S && info_d.di == 2'd2;
      if (ctl.start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 5'd1;
        if (step == STEP_LAST) begin
          run <= 1'b0;
        end
      end
      if (ctl.clear) begin
        sum <= '{default: '0};
      end else if (vld_d && info_d.dest == DST_S) begin
        sum[info_d.di] <= sat48(50'(sum[info_d.di]) + 50'(term));
      end
    end
  end

endmodule

/* sv/skinned_vertex_bounds.sv */
// Linear blend skinning with a running frame bounding box. A joint load beat
// (cmd 0) is written to the joint memory without stalling the input. A weight
// beat (cmd 1) holds the input through one joint memory read, then 27 products
// through a single shared 32x32 multiplier (12 for q*v, 12 for the conjugate
// product, 3 for the bias), each registered, then rounded and accumulated. A
// last weight then saturates the vertex (FIN1), updates the box (FIN2) and
// loads the output register (OUTP), and waits there while the output is stalled.
module skinned_vertex_bounds
  import svb_pkg::*;
#(
  parameter int JOINT_COUNT = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  typedef enum logic [5:0] {
    IDLE = 6'b000001,
    READ = 6'b000010,
    RUN  = 6'b000100,
    FIN1 = 6'b001000,
    FIN2 = 6'b010000,
    OUTP = 6'b100000
  } state_t;

  state_t             state;
  logic               accept;
  logic               ok_in;
  logic               ok;
  logic               last;
  logic [30:0]        bias;
  logic signed [31:0] vec [3];
  joint_t             wdata;
  joint_t             rdata;
  eng_ctl_t           ctl;
  logic signed [47:0] sum [3];
  logic               done;
  logic signed [31:0] vreg [3];
  logic signed [31:0] run_min [3];
  logic signed [31:0] run_max [3];

  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign ok_in    = int'(in_data.joint_index) < JOINT_COUNT;

  assign wdata.pos_x = in_data.vec_x;
  assign wdata.pos_y = in_data.vec_y;
  assign wdata.pos_z = in_data.vec_z;
  assign wdata.rot_x = in_data.quat_x;
  assign wdata.rot_y = in_data.quat_y;
  assign wdata.rot_z = in_data.quat_z;
  assign wdata.rot_w = in_data.quat_w;

  assign ctl.start = (state == READ);
  assign ctl.clear = (state == FIN1);
  assign ctl.ok    = ok;

  svb_joint_mem #(
    .DEPTH (JOINT_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept && !in_data.cmd && ok_in),
    .addr  (AW'(in_data.joint_index)),
    .wdata (wdata),
    .rdata (rdata)
  );

  svb_engine u_eng (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .joint (rdata),
    .vec   (vec),
    .bias  (bias),
    .sum   (sum),
    .done  (done)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      ok     <= ok_in;
      last   <= in_data.last_weight;
      bias   <= in_data.bias;
      vec[0] <= in_data.vec_x;
      vec[1] <= in_data.vec_y;
      vec[2] <= in_data.vec_z;
    end
    if (state == FIN1) begin
      for (int i = 0; i < 3; i++) begin
        vreg[i] <= sat32(50'(sum[i]));
      end
    end
    if (state == OUTP && !(out_valid && out_stall)) begin
      out_data.vert_x    <= vreg[0];
      out_data.vert_y    <= vreg[1];
      out_data.vert_z    <= vreg[2];
      out_data.box_min_x <= sat32(50'(run_min[0]) - 50'(HALF_Q16));
      out_data.box_min_y <= sat32(50'(run_min[1]) - 50'(HALF_Q16));
      out_data.box_min_z <= sat32(50'(run_min[2]) - 50'(HALF_Q16));
      out_data.box_max_x <= sat32(50'(run_max[0]) + 50'(HALF_Q16));
      out_data.box_max_y <= sat32(50'(run_max[1]) + 50'(HALF_Q16));
      out_data.box_max_z <= sat32(50'(run_max[2]) + 50'(HALF_Q16));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      run_min   <= '{default: S32_MAX};
      run_max   <= '{default: S32_MIN};
    end else begin
      if (state == OUTP && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && in_data.cmd) begin
            state <= READ;
            if (in_data.frame_start) begin
              run_min <= '{default: S32_MAX};
              run_max <= '{default: S32_MIN};
            end
          end
        end
        READ: state <= RUN;
        RUN: begin
          if (done) begin
            state <= last ? FIN1 : IDLE;
          end
        end
        FIN1: state <= FIN2;
        FIN2: begin
          for (int i = 0; i < 3; i++) begin
            if (vreg[i] < run_min[i]) run_min[i] <= vreg[i];
            if (vreg[i] > run_max[i]) run_max[i] <= vreg[i];
          end
          state <= OUTP;
        end
        OUTP: begin
          if (!(out_valid && out_stall)) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* sv/svb_checker.sv */
`include "skinned_vertex_bounds_assert.svh"

module svb_checker
  import svb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `SVB_ASSERT_NEXT(a_weight_holds_input, in_valid && !in_stall && in_data.cmd, in_stall, "weight beat did not hold input")
  `SVB_ASSERT_NOW(a_result_after_busy, $rose(out_valid), $past(in_stall), "result without busy period")
  `SVB_ASSERT_NOW(a_box_ordered, out_valid, out_data.box_min_x <= out_data.box_max_x && out_data.box_min_y <= out_data.box_max_y && out_data.box_min_z <= out_data.box_max_z, "box min above max")
  `SVB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output beat changed")

endmodule

bind skinned_vertex_bounds svb_checker u_chk (.*);
